// ===== rtl/gtb_pkg.sv =====
// Shared constants, types and tables for the GUID text parser.
package gtb_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned BYTE_IDX_W = 4;

    localparam logic [POS_W-1:0]  GUID_TEXT_LEN = 6'd36;
    localparam logic [POS_W-1:0]  POS_SAT       = 6'd37;
    localparam logic [CHAR_W-1:0] DASH_CHAR     = 8'h2D;

    localparam logic [POS_W-1:0] DASH_POS_0 = 6'd8;
    localparam logic [POS_W-1:0] DASH_POS_1 = 6'd13;
    localparam logic [POS_W-1:0] DASH_POS_2 = 6'd18;
    localparam logic [POS_W-1:0] DASH_POS_3 = 6'd23;

    // GUID byte slot for each text byte (first three groups reversed)
    localparam logic [BYTE_IDX_W-1:0] BYTE_PLACE [16] = '{
        4'd3, 4'd2, 4'd1, 4'd0, 4'd5, 4'd4, 4'd7, 4'd6,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    typedef struct packed {
        logic                  bad;
        logic                  take_upper;
        logic                  put_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic [NIBBLE_W-1:0]   nibble;
    } dec_t;

endpackage

// ===== rtl/gtb_decode.sv =====
// Per-character decode: position check, hex digit value and byte slot.
module gtb_decode
(
    input  logic [gtb_pkg::POS_W-1:0]  position,
    input  logic [gtb_pkg::CHAR_W-1:0] text_char,
    output gtb_pkg::dec_t              dec
);

    logic                              dash_pos;
    logic                              hex_ok;
    logic [gtb_pkg::NIBBLE_W-1:0]      hex_val;
    logic [2:0]                        dashes;
    logic [gtb_pkg::POS_W-1:0]         digit_full;
    logic [4:0]                        digit_idx;

    assign dash_pos = (position == gtb_pkg::DASH_POS_0) || (position == gtb_pkg::DASH_POS_1) ||
                      (position == gtb_pkg::DASH_POS_2) || (position == gtb_pkg::DASH_POS_3);

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = '0;
        case (text_char) inside
            [8'h30:8'h39]: hex_val = 4'(text_char - 8'h30);
            [8'h61:8'h66]: hex_val = 4'(text_char - 8'h57);
            [8'h41:8'h46]: hex_val = 4'(text_char - 8'h37);
            default:       hex_ok  = 1'b0;
        endcase
    end

    assign dashes = 3'(position > gtb_pkg::DASH_POS_0) + 3'(position > gtb_pkg::DASH_POS_1) +
                    3'(position > gtb_pkg::DASH_POS_2) + 3'(position > gtb_pkg::DASH_POS_3);
    assign digit_full = position - gtb_pkg::POS_W'(dashes);
    assign digit_idx  = digit_full[4:0];

    always_comb
    begin
        dec            = '0;
        dec.nibble     = hex_val;
        dec.byte_index = gtb_pkg::BYTE_PLACE[digit_idx[4:1]];
        if (position >= gtb_pkg::GUID_TEXT_LEN)
        begin
            dec.bad = 1'b1;
        end
        else if (dash_pos)
        begin
            dec.bad = (text_char != gtb_pkg::DASH_CHAR);
        end
        else
        begin
            dec.bad        = !hex_ok;
            dec.take_upper = !digit_idx[0];
            dec.put_byte   = digit_idx[0];
        end
    end

endmodule

// ===== rtl/guid_text_to_bytes.sv =====
// Top level: GUID text stream in, 16 mixed-endian GUID bytes out.
// Throughput: one character per cycle, except that a last character waits while both output entries are full.
// The last character is registered at the input, then its result is registered in the output stage.
// A two-entry output stage lets input continue while a result waits.
// Reset (rst_n low, async) clears position, error flag and all valid flags.
module guid_text_to_bytes
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_char
    input  logic         s_tlast,   // end_of_text
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] bytes_low, [127:64] bytes_high
    output logic         m_tuser    // parse_ok
);

    localparam int unsigned WW = gtb_pkg::WORD_W;

    logic                          in_valid_reg;
    logic [gtb_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          in_last_reg;

    logic [gtb_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          bad_reg, bad_next;
    logic [gtb_pkg::NIBBLE_W-1:0]  upper_reg, upper_next;
    logic [WW-1:0]                 low_acc_reg, low_acc_next;
    logic [WW-1:0]                 high_acc_reg, high_acc_next;

    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [2*WW-1:0]               out_data_reg;
    logic                          skid_valid_reg;
    logic                          skid_ok_reg;
    logic [2*WW-1:0]               skid_data_reg;

    gtb_pkg::dec_t                 dec;
    logic                          proc_fire;
    logic                          push;
    logic                          pop;
    logic                          res_ok;
    logic [2*WW-1:0]               res_data;
    logic [7:0]                    new_byte;

    gtb_decode u_decode
    (
        .position  (pos_reg),
        .text_char (in_char_reg),
        .dec       (dec)
    );

    assign proc_fire = in_valid_reg && !(in_last_reg && skid_valid_reg);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign push      = proc_fire && in_last_reg;
    assign pop       = out_valid_reg && m_tready;
    assign new_byte  = {upper_reg, dec.nibble};

    always_comb
    begin
        bad_next      = bad_reg | dec.bad;
        upper_next    = dec.take_upper ? dec.nibble : upper_reg;
        pos_next      = (pos_reg < gtb_pkg::POS_SAT) ? pos_reg + 1'b1 : pos_reg;
        low_acc_next  = low_acc_reg;
        high_acc_next = high_acc_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (dec.put_byte && dec.byte_index == 4'(k))
            begin
                low_acc_next[8*k +: 8] = new_byte;
            end
            if (dec.put_byte && dec.byte_index == 4'(k + 8))
            begin
                high_acc_next[8*k +: 8] = new_byte;
            end
        end
        res_ok   = !bad_next && (pos_next == gtb_pkg::GUID_TEXT_LEN);
        res_data = res_ok ? {high_acc_next, low_acc_next} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            pos_reg <= in_last_reg ? '0 : pos_next;
            bad_reg <= in_last_reg ? 1'b0 : bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            upper_reg    <= upper_next;
            low_acc_reg  <= low_acc_next;
            high_acc_reg <= high_acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= out_valid_reg && !pop;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_ok_reg   <= skid_ok_reg;
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_ok_reg   <= res_ok;
                out_data_reg <= res_data;
            end
            else
            begin
                skid_ok_reg   <= res_ok;
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/gtb_checker.sv =====
// Port-level checker for the GUID text parser, bound to the top level.
module gtb_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    // held result must not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // input backpressure only while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending output");

    // failed parse carries all-zero bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result has nonzero bytes");

    // input stall clears once the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |=> s_tready)
        else $error("input stalled after empty output");

endmodule

bind guid_text_to_bytes gtb_checker u_gtb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
